// ===== hw/rtl/trs_pkg.sv =====
// shared types and constants of the threshold run-length smoother
// no dependencies; imported by every module of the block
`default_nettype none

package trs_pkg;

   // sizes of the smoothing window and the pending buffer
   localparam int MAX_WINDOW  = 15;
   localparam int BUF_DEPTH   = MAX_WINDOW + 1;
   localparam int AIDX_W      = $clog2(BUF_DEPTH);
   localparam int PEND_W      = $clog2(BUF_DEPTH + 1);
   localparam int BVALID_W    = $clog2(MAX_WINDOW + 1);
   localparam int WIN_W       = 4;
   localparam int NEIGH_W     = $clog2(2 * MAX_WINDOW + 1);

   // payload widths
   localparam int SCORE_W     = 16;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW        = 2'd2;

   // configuration reset values
   localparam logic signed [SCORE_W-1:0] CUTOFF_RESET = '0;
   localparam logic [WIN_W-1:0]          WINDOW_RESET = 4'd3;

   // configuration seen by front and back
   typedef struct packed {
      logic signed [SCORE_W-1:0] cutoff;
      logic                      distance_mode;
      logic [WIN_W-1:0]          window;
   } trs_cfg_type;

   // classified request travelling from front to back
   typedef struct packed {
      logic pass;
      logic fin;
   } trs_item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/trs_front.sv =====
// front end: accepts requests, thresholds the score, queues the raw flag
// depends on trs_pkg
`default_nettype none

module trs_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire trs_pkg::trs_cfg_type               cfg,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [trs_pkg::SCORE_W-1:0] req_score,
   input  wire logic                               req_final_position,
   output logic                                    item_valid,
   output trs_pkg::trs_item_type                   item,
   input  wire logic                               item_pop
);
   import trs_pkg::*;

   trs_item_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;
   logic                      push;
   logic                      pass;

   // threshold test on the incoming score
   always_comb begin
      if (cfg.distance_mode) begin
         pass = (req_score > $signed(SCORE_W'(0))) && (req_score <= cfg.cutoff);
      end else begin
         pass = (req_score >= cfg.cutoff);
      end
   end

   assign req_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{pass: pass, fin: req_final_position};
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("request queue overfilled");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (count_ff != '0))
      else $error("request queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/trs_back.sv =====
// back end: pending and history flags, run counting and result emission
// depends on trs_pkg
`default_nettype none

module trs_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire trs_pkg::trs_cfg_type  cfg,
   input  wire logic                  item_valid,
   input  wire trs_pkg::trs_item_type item,
   output logic                       item_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_reliable,
   output logic                       rsp_run_last
);
   import trs_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type               state_ff;
   logic [BUF_DEPTH-1:0]    ahead_ff;
   logic [MAX_WINDOW-1:0]   behind_ff;
   logic [BVALID_W-1:0]     bvalid_ff;
   logic [PEND_W-1:0]       pend_ff;
   logic                    fin_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_reliable_ff;
   logic                    rsp_run_last_ff;

   logic [PEND_W-1:0]       win_ext;
   logic [PEND_W-1:0]       pend_m1;
   logic [PEND_W-1:0]       lim_fwd;
   logic [BVALID_W-1:0]     lim_bwd;
   logic [NEIGH_W-1:0]      neigh;
   logic [BUF_DEPTH-1:0]    fwd_run;
   logic [MAX_WINDOW-1:0]   bwd_run;
   logic                    run_fwd;
   logic                    run_bwd;
   logic                    rel;
   logic                    emit_cond;
   logic                    out_free;
   logic                    load_rsp;

   assign win_ext   = PEND_W'(cfg.window);
   assign emit_cond = fin_ff ? (pend_ff != '0) : (pend_ff > win_ext);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp  = (state_ff == ST_DRAIN) && emit_cond && out_free;
   assign item_pop  = (state_ff == ST_IDLE) && item_valid;

   // neighbour count of the oldest pending position
   always_comb begin
      pend_m1 = pend_ff - 1'b1;
      lim_fwd = (pend_m1 > win_ext) ? win_ext : pend_m1;
      lim_bwd = (bvalid_ff > BVALID_W'(cfg.window)) ? BVALID_W'(cfg.window) : bvalid_ff;
      fwd_run = '0;
      run_fwd = 1'b1;
      for (int j = 1; j < BUF_DEPTH; j++) begin
         if (!ahead_ff[j] || (PEND_W'(j) > lim_fwd)) begin
            run_fwd = 1'b0;
         end
         fwd_run[j] = run_fwd;
      end
      bwd_run = '0;
      run_bwd = 1'b1;
      for (int j = 0; j < MAX_WINDOW; j++) begin
         if (!behind_ff[j] || (BVALID_W'(j) >= lim_bwd)) begin
            run_bwd = 1'b0;
         end
         bwd_run[j] = run_bwd;
      end
      // both runs are prefixes, so their lengths are their popcounts
      neigh = NEIGH_W'($countones(fwd_run)) + NEIGH_W'($countones(bwd_run));
      rel = ahead_ff[0] &&
            ((cfg.window == '0) || (neigh >= (NEIGH_W'(cfg.window) - NEIGH_W'(1))));
   end

   // sequencer, flag buffers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ahead_ff        <= '0;
         behind_ff       <= '0;
         bvalid_ff       <= '0;
         pend_ff         <= '0;
         fin_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_reliable_ff <= 1'b0;
         rsp_run_last_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               // append the raw flag of the popped request
               if (item_valid) begin
                  if (pend_ff < PEND_W'(BUF_DEPTH)) begin
                     ahead_ff[pend_ff[AIDX_W-1:0]] <= item.pass;
                     pend_ff <= pend_ff + 1'b1;
                  end
                  fin_ff   <= item.fin;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (emit_cond) begin
                  // retire the oldest pending position
                  if (out_free) begin
                     rsp_valid_ff    <= 1'b1;
                     rsp_reliable_ff <= rel;
                     rsp_run_last_ff <= fin_ff && (pend_ff == PEND_W'(1));
                     behind_ff       <= {behind_ff[MAX_WINDOW-2:0], rel};
                     if (bvalid_ff < BVALID_W'(MAX_WINDOW)) begin
                        bvalid_ff <= bvalid_ff + 1'b1;
                     end
                     ahead_ff <= ahead_ff >> 1;
                     pend_ff  <= pend_m1;
                  end
               end else begin
                  // stream end clears history for the next stream
                  if (fin_ff) begin
                     ahead_ff  <= '0;
                     behind_ff <= '0;
                     bvalid_ff <= '0;
                     pend_ff   <= '0;
                  end
                  fin_ff   <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_reliable = rsp_reliable_ff;
   assign rsp_run_last = rsp_run_last_ff;

`ifndef ASSERT_OFF
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      (pend_ff <= PEND_W'(BUF_DEPTH)) && (bvalid_ff <= BVALID_W'(MAX_WINDOW)))
      else $error("pending or history count out of range");

   a_stream_end_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !emit_cond && fin_ff)
      |=> (pend_ff == '0 && bvalid_ff == '0 && state_ff == ST_IDLE))
      else $error("history not cleared after final position");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && fin_ff && pend_ff == PEND_W'(1)) |=> (pend_ff == '0))
      else $error("final result left positions pending");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/threshold_run_length_smoother_top.sv =====
// Threshold run-length smoother.
// Requests (req_score, signed Q8.8, and req_final_position) enter on a
// valid/ready channel. Each score is thresholded against csr cutoff (score
// test, or 0 < score <= cutoff in distance mode); a passing position stays
// reliable only when its run of passing neighbours ahead plus reliable ones
// behind, up to window positions each way, reaches window-1. Results leave
// in position order on the rsp_ channel; a position's result appears once
// window later positions have arrived, and the final position flushes all
// pending results, marking the last one with rsp_run_last.
// Flow: a request waits in a two-entry queue, then the back end appends it,
// releases the results it makes ready one at a time and ends with a closing
// step before it takes the next item.
// The output register lets the front keep queueing while a result waits; a
// stalled receiver holds the back end, and the queue then fills.
// Reset (synchronous) empties queue and history; cutoff 0, score mode, window 3.
// Registers must be written through csr_ while the block is idle; unenforced.
// depends on trs_pkg, trs_front, trs_back
`default_nettype none

module threshold_run_length_smoother_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [trs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [trs_pkg::SCORE_W-1:0]          csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [trs_pkg::SCORE_W-1:0]   req_score,
   input  wire logic                                 req_final_position,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_reliable,
   output logic                                      rsp_run_last
);
   import trs_pkg::*;

   trs_cfg_type  cfg_ff, cfg_in;
   logic         item_valid;
   trs_item_type item;
   logic         item_pop;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CUTOFF:        cfg_in.cutoff        = $signed(csr_data);
            CSR_DISTANCE_MODE: cfg_in.distance_mode = csr_data[0];
            CSR_WINDOW:        cfg_in.window        = csr_data[WIN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{cutoff: CUTOFF_RESET, distance_mode: 1'b0, window: WINDOW_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_score          (req_score),
      .req_final_position (req_final_position),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop)
   );

   trs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .item_valid   (item_valid),
      .item         (item),
      .item_pop     (item_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_reliable (rsp_reliable),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire

// ===== dv/trs_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard for the threshold run-length smoother: predicts smoothed flags
// per position and checks each response against the oldest prediction
// depends on trs_pkg for widths, reset values and register indexes

package trs_scoreboard_pkg;
   import trs_pkg::*;

   localparam int REPORT_LIMIT = 40;

   typedef struct packed {
      logic reliable;
      logic run_last;
   } smoothed_flag_type;

   class smoother_scoreboard;
      // register copy
      logic signed [SCORE_W-1:0] cutoff;
      logic                      distance_mode;
      logic [WIN_W-1:0]          window;

      // raw pass flags of pending positions, bit 0 oldest
      logic [BUF_DEPTH-1:0]  raw_flags;
      // smoothed flags of retired positions, bit 0 newest
      logic [MAX_WINDOW-1:0] smoothed_flags;
      int history_count;
      int pending;

      smoothed_flag_type expected_flags[$];

      int mismatch_count;
      int position_count;
      int stream_count;
      int result_count;
      int reliable_count;

      function new();
         cutoff         = CUTOFF_RESET;
         distance_mode  = 1'b0;
         window         = WINDOW_RESET;
         raw_flags      = '0;
         smoothed_flags = '0;
         history_count  = 0;
         pending        = 0;
         mismatch_count = 0;
         position_count = 0;
         stream_count   = 0;
         result_count   = 0;
         reliable_count = 0;
      endfunction

      function int span();
         return (window > MAX_WINDOW) ? MAX_WINDOW : int'(window);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [SCORE_W-1:0] data);
         case (index)
            CSR_CUTOFF:        cutoff = signed'(data);
            CSR_DISTANCE_MODE: distance_mode = data[0];
            CSR_WINDOW:        window = data[WIN_W-1:0];
            default: ;
         endcase
      endfunction

      // smooth the oldest pending position and move it into the history
      function void retire_oldest(bit last);
         int  w;
         int  lim;
         int  j;
         int  neigh;
         bit  rel;
         w     = span();
         neigh = 0;
         rel   = 1'b0;
         if (raw_flags[0]) begin
            // run of raw passes ahead
            lim = (pending - 1 < w) ? pending - 1 : w;
            for (j = 1; j <= lim; j++) begin
               if (!raw_flags[j]) break;
               neigh++;
            end
            // run of already smoothed flags behind
            lim = (history_count < w) ? history_count : w;
            for (j = 0; j < lim; j++) begin
               if (!smoothed_flags[j]) break;
               neigh++;
            end
            rel = (neigh >= w - 1);
         end
         smoothed_flags = {smoothed_flags[MAX_WINDOW-2:0], rel};
         if (history_count < MAX_WINDOW) history_count++;
         raw_flags = {1'b0, raw_flags[BUF_DEPTH-1:1]};
         pending--;
         expected_flags.push_back('{reliable: rel, run_last: last});
      endfunction

      // accepted request: threshold it and release what it makes ready
      function void note_request(logic signed [SCORE_W-1:0] score, logic fin);
         bit pass_flag;
         if (distance_mode) pass_flag = (score > 0) && (score <= cutoff);
         else pass_flag = (score >= cutoff);
         position_count++;
         if (pending < BUF_DEPTH) begin
            raw_flags[pending] = pass_flag;
            pending++;
         end
         if (fin) begin
            stream_count++;
            while (pending > 0) retire_oldest(pending == 1);
            raw_flags      = '0;
            smoothed_flags = '0;
            history_count  = 0;
            pending        = 0;
         end else begin
            while (pending > span()) retire_oldest(1'b0);
         end
      endfunction

      task report(string what);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
      endtask

      task check_result(logic reliable, logic run_last);
         smoothed_flag_type want;
         result_count++;
         if (expected_flags.size() == 0) begin
            report($sformatf("result %0d not expected (reliable=%b run_last=%b)",
                             result_count, reliable, run_last));
            return;
         end
         want = expected_flags.pop_front();
         if (want.reliable) reliable_count++;
         if (reliable !== want.reliable)
            report($sformatf("result %0d reliable=%b, predicted %b",
                             result_count, reliable, want.reliable));
         if (run_last !== want.run_last)
            report($sformatf("result %0d run_last=%b, predicted %b",
                             result_count, run_last, want.run_last));
      endtask
   endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// top of the threshold run-length smoother testbench: clock, reset, request,
// response and register drivers, watchdog and final verdict
// depends on trs_pkg, trs_scoreboard_pkg and threshold_run_length_smoother_top

module testbench;
   import trs_pkg::*;
   import trs_scoreboard_pkg::*;

   localparam int SETTLE_CYCLES    = 16;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int STALL_LIMIT      = 2000;
   localparam int RANDOM_POSITIONS = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [SCORE_W-1:0]        csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [SCORE_W-1:0] req_score = '0;
   logic                      req_final_position = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_reliable;
   logic                      rsp_run_last;

   logic steady_flow = 1'b0;
   logic hold_off_request = 1'b0;
   int   register_writes = 0;
   int   random_positions = 0;

   smoother_scoreboard flag_board = new();

   threshold_run_length_smoother_top dut (
      .clock,
      .reset,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data,
      .req_valid,
      .req_ready,
      .req_score,
      .req_final_position,
      .rsp_valid,
      .rsp_ready,
      .rsp_reliable,
      .rsp_run_last
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 12);
   endfunction

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   // score on the wanted side of the current threshold, often on its edge
   function automatic logic signed [SCORE_W-1:0] pick_score(bit want_pass);
      int c;
      int v;
      bit near;
      logic signed [SCORE_W-1:0] s;
      c    = flag_board.cutoff;
      near = ($urandom_range(99) < 25);
      if (!flag_board.distance_mode) begin
         if (want_pass || c == -32768) v = near ? c : rand_between(c, 32767);
         else v = near ? c - 1 : rand_between(-32768, c - 1);
      end else if (want_pass && c >= 1) begin
         if (near) v = $urandom_range(1, 0) ? c : 1;
         else v = rand_between(1, c);
      end else if (c < 32767 && $urandom_range(1, 0)) begin
         v = near ? c + 1 : rand_between(c + 1, 32767);
      end else begin
         v = near ? 0 : rand_between(-32768, 0);
      end
      s = v[SCORE_W-1:0];
      return s;
   endfunction

   // register write; valid drops at the accepting edge, and the scoreboard copy is updated
   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [SCORE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      flag_board.write_reg(index, value);
      register_writes++;
      @(posedge clock);
   endtask

   task automatic configure(logic [SCORE_W-1:0] cutoff, logic mode, logic [WIN_W-1:0] span);
      logic [SCORE_W-1:0] d;
      write_register(CSR_CUTOFF, cutoff);
      d    = SCORE_W'($urandom());
      d[0] = mode;
      write_register(CSR_DISTANCE_MODE, d);
      d = SCORE_W'($urandom());
      d[WIN_W-1:0] = span;
      write_register(CSR_WINDOW, d);
   endtask

   // one request; valid stays high into the next one when no gap follows
   task automatic send_position(logic signed [SCORE_W-1:0] score, logic fin);
      int gap;
      req_valid          <= 1'b1;
      req_score          <= score;
      req_final_position <= fin;
      do @(posedge clock); while (!req_ready);
      flag_board.note_request(score, fin);
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pauses until every predicted response is in, then lets the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (flag_board.expected_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // alternating runs of passing and failing positions with some noise
   task automatic run_stream(int length, bit close_stream);
      bit passing;
      int run_left;
      int k;
      logic signed [SCORE_W-1:0] s;
      passing  = 1'($urandom_range(1, 0));
      run_left = 0;
      for (k = 0; k < length; k++) begin
         if (run_left == 0) begin
            passing  = !passing;
            run_left = $urandom_range(flag_board.span() + 3, 1);
         end
         run_left--;
         if ($urandom_range(99) < 15) s = SCORE_W'($urandom());
         else s = pick_score(passing);
         send_position(s, close_stream && (k == length - 1));
      end
   endtask

   task automatic random_phase();
      int r;
      int length;
      logic [SCORE_W-1:0] c;
      logic [WIN_W-1:0] w;
      r = $urandom_range(99);
      if (r < 12) c = 16'h8000;
      else if (r < 24) c = 16'h7FFF;
      else if (r < 65) c = 16'(rand_between(-1024, 1024));
      else c = SCORE_W'($urandom());
      r = $urandom_range(99);
      if (r < 20) w = '0;
      else if (r < 35) w = 4'd15;
      else w = 4'($urandom_range(6, 1));
      if ($urandom_range(99) < 25) begin
         // only the span changes, possibly in the middle of an open stream
         c = SCORE_W'($urandom());
         c[WIN_W-1:0] = w;
         write_register(CSR_WINDOW, c);
      end else begin
         configure(c, 1'($urandom_range(1, 0)), w);
      end
      steady_flow <= ($urandom_range(99) < 25);
      if (flag_board.span() == MAX_WINDOW && $urandom_range(1, 0)) length = $urandom_range(24, 16);
      else length = $urandom_range(24, 1);
      run_stream(length, $urandom_range(99) < 80);
      random_positions += length;
      wait_idle();
   endtask

   // response side: random stalls, long hold-off on request
   initial begin : receiver
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request <= 1'b0;
            rsp_ready        <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (steady_flow || $urandom_range(99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall = pick_gap();
         end
      end
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         flag_board.check_result(rsp_reliable, rsp_run_last);
   end

   // watchdog on cycles without any handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t timeout: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: score test at cutoff 0, span 3
      send_position(16'sd0, 1'b0);
      send_position(16'sh7FFF, 1'b0);
      send_position(16'sd1, 1'b0);
      send_position(-16'sd1, 1'b0);
      send_position(16'sh8000, 1'b0);
      send_position(16'sh0100, 1'b0);
      send_position(16'sh0200, 1'b0);
      send_position(16'sd0, 1'b1);
      wait_idle();

      // distance test, span zero: each position leaves on its own request
      configure(16'h0100, 1'b1, 4'd0);
      send_position(16'sd0, 1'b0);
      send_position(16'sd1, 1'b0);
      send_position(16'sh0100, 1'b0);
      send_position(16'sh0101, 1'b0);
      send_position(-16'sd5, 1'b0);
      send_position(16'sh7FFF, 1'b1);
      wait_idle();

      // unused register index, then a span cut in the middle of a stream
      write_register(CSR_UNUSED, SCORE_W'($urandom()));
      configure(16'h8000, 1'b0, 4'd12);
      repeat (8) send_position(SCORE_W'($urandom()), 1'b0);
      wait_idle();
      write_register(CSR_WINDOW, 16'h0001);
      send_position(16'sh8000, 1'b0);
      send_position(16'sh7FFF, 1'b1);
      wait_idle();

      // widest span and highest cutoff: sixteen results from one final request
      configure(16'h7FFF, 1'b1, 4'd15);
      run_stream(16, 1'b1);
      random_positions += 16;
      wait_idle();

      // receiver holds off while the sender keeps pushing
      configure(16'h8000, 1'b0, 4'd0);
      hold_off_request <= 1'b1;
      steady_flow      <= 1'b1;
      run_stream(30, 1'b1);
      random_positions += 30;
      wait_idle();

      while (random_positions < RANDOM_POSITIONS) random_phase();
      wait_idle();

      if (flag_board.expected_flags.size() != 0)
         flag_board.report($sformatf("%0d predicted results never arrived",
                                     flag_board.expected_flags.size()));
      $display("ran %0d positions in %0d closed streams, %0d results (%0d reliable)",
               flag_board.position_count, flag_board.stream_count,
               flag_board.result_count, flag_board.reliable_count);
      $display("%0d register writes across both threshold modes and spans 0 to 15, %0d mismatches",
               register_writes, flag_board.mismatch_count);
      if (flag_board.mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
